@@ hdl/bpmp_pkg.sv @@
// Package: shared constants and types for the binned pairwise max block
`timescale 1ns / 1ps
package bpmp_pkg;

  localparam int MAX_POINTS_DEF = 256;
  localparam int MAX_BINS_DEF   = 64;
  localparam int MAX_DIMS_DEF   = 4;

  localparam int COORD_W = 16;
  localparam int DIFF_W  = 17;
  localparam int SQ_W    = 32;
  localparam int DSUM_W  = 35;
  localparam int BW_W    = 18;
  localparam int ROOT_W  = 18;
  localparam int DIMS_W  = 3;
  localparam int BIDX_W  = 6;

  localparam logic [1:0] REG_SPATIAL_DIMS = 2'd0;
  localparam logic [1:0] REG_FEATURE_DIMS = 2'd1;
  localparam logic [1:0] REG_BIN_WIDTH    = 2'd2;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PAIR_RD,
    ST_PAIR_SUB,
    ST_PAIR_SQ,
    ST_PAIR_SUM,
    ST_PAIR_ROOT,
    ST_PAIR_BIN,
    ST_PAIR_LOOK,
    ST_PAIR_UPD,
    ST_OUT_RD,
    ST_OUT_ROOT,
    ST_OUT_SEND,
    ST_CLEAR
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic store_pt;
    logic rd_pair;
    logic sub;
    logic sq;
    logic sum;
    logic root_start;
    logic root_out;
    logic bin_step;
    logic upd;
    logic rd_bin;
    logic out_load;
    logic clr_bin;
    logic run_clear;
  } dp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic root_done;
    logic bin_done;
    logic full;
    logic pair_last;
    logic bin_last;
    logic clr_last;
  } dp_sts_t;

endpackage

@@ hdl/bpmp_isqrt.sv @@
// Iterative integer square root, one result bit per cycle
`timescale 1ns / 1ps
module bpmp_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [bpmp_pkg::DSUM_W-1:0] radicand,
  output logic [bpmp_pkg::ROOT_W-1:0] root,
  output logic                        done
);
  import bpmp_pkg::*;

  localparam int RAD_W = 2 * ROOT_W;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_r, rad_nxt;
  logic [RAD_W-1:0]  rem_r, rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [RAD_W-1:0]  trial;
  logic [RAD_W-1:0]  rem_sh;

  // One restoring step: bring down two radicand bits, try root*4+1
  always_comb begin
    rem_sh   = {rem_r[RAD_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial    = {{(RAD_W-ROOT_W-2){1'b0}}, root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rad_nxt  = {{(RAD_W-DSUM_W){1'b0}}, radicand};
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNT_W'(ROOT_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[ROOT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) busy_r <= 1'b0;
    else        busy_r <= busy_nxt;
  end

  assign root = root_r;
  assign done = !busy_r && !start;

endmodule

@@ hdl/bpmp_datapath.sv @@
// Datapath: point memories, pair distance unit, bin divider, bin store, output register
`timescale 1ns / 1ps
module bpmp_datapath #(
  parameter int MAX_POINTS = bpmp_pkg::MAX_POINTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bpmp_pkg::dp_cmd_t            cmd,
  output bpmp_pkg::dp_sts_t            sts,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [bpmp_pkg::BW_W-1:0]    cfg_data,
  input  logic [4*bpmp_pkg::COORD_W-1:0] in_space,
  input  logic [4*bpmp_pkg::COORD_W-1:0] in_feat,
  output logic [bpmp_pkg::BIDX_W-1:0]  out_bin_index,
  output logic [bpmp_pkg::ROOT_W-1:0]  out_prefix_max_dist,
  output logic                         out_bin_overflow,
  output logic                         out_final_bin
);
  import bpmp_pkg::*;

  localparam int MAX_BINS = MAX_BINS_DEF;
  localparam int PA_W  = $clog2(MAX_POINTS);
  localparam int PC_W  = $clog2(MAX_POINTS + 1);
  localparam int BA_W  = $clog2(MAX_BINS);
  localparam int BIN_W = ROOT_W + 1;

  // Configuration registers
  logic [DIMS_W-1:0] sdims_r, fdims_r;
  logic [BW_W-1:0]   bw_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sdims_r <= DIMS_W'(2);
      fdims_r <= DIMS_W'(1);
      bw_r    <= BW_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPATIAL_DIMS: sdims_r <= cfg_data[DIMS_W-1:0];
        REG_FEATURE_DIMS: fdims_r <= cfg_data[DIMS_W-1:0];
        REG_BIN_WIDTH:    bw_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [2:0] sd_eff, fd_eff;
  logic [BW_W-1:0] bw_eff;
  assign sd_eff = (sdims_r == '0) ? 3'd1 : (sdims_r > 3'd4) ? 3'd4 : sdims_r;
  assign fd_eff = (fdims_r == '0) ? 3'd1 : (fdims_r > 3'd4) ? 3'd4 : fdims_r;
  assign bw_eff = (bw_r == '0) ? BW_W'(1) : bw_r;

  // Point count and pair indices
  logic [PC_W-1:0] cnt_r;
  logic [PA_W-1:0] pi_r, pj_r;
  assign sts.full = (cnt_r == PC_W'(MAX_POINTS));
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pi_r  <= '0;
      pj_r  <= '0;
    end else if (cmd.run_clear) begin
      cnt_r <= '0;
      pi_r  <= '0;
      pj_r  <= '0;
    end else begin
      if (cmd.store_pt && !sts.full) cnt_r <= cnt_r + 1'b1;
      if (cmd.upd) begin
        if (PC_W'(pj_r) + 1'b1 == cnt_r) begin
          pj_r <= '0;
          pi_r <= pi_r + 1'b1;
        end else begin
          pj_r <= pj_r + 1'b1;
        end
      end
    end
  end
  assign sts.pair_last = (PC_W'(pj_r) + 1'b1 == cnt_r) && (PC_W'(pi_r) + 1'b1 == cnt_r);

  // Point memories: one write port, two registered read ports
  logic [8*COORD_W-1:0] pmem [MAX_POINTS];
  logic [8*COORD_W-1:0] pa_r, pb_r;
  always_ff @(posedge clk) begin
    if (cmd.store_pt && !sts.full) pmem[cnt_r[PA_W-1:0]] <= {in_space, in_feat};
    if (cmd.rd_pair) begin
      pa_r <= pmem[pi_r];
      pb_r <= pmem[pj_r];
    end
  end

  // Magnitude of each coordinate difference
  logic signed [DIFF_W-1:0] diff_r [8];
  logic [COORD_W-1:0]       dmag [8];
  always_comb begin
    for (int k = 0; k < 8; k++)
      dmag[k] = diff_r[k][DIFF_W-1] ? COORD_W'(-diff_r[k]) : diff_r[k][COORD_W-1:0];
  end

  // Per-coordinate differences, then squares, then sums
  logic [SQ_W-1:0]          sq_r [8];
  logic [DSUM_W-1:0]        ssum_r, fsum_r;
  always_ff @(posedge clk) begin
    for (int k = 0; k < 8; k++) begin
      if (cmd.sub)
        diff_r[k] <= DIFF_W'($signed(pa_r[k*COORD_W +: COORD_W]))
                   - DIFF_W'($signed(pb_r[k*COORD_W +: COORD_W]));
      if (cmd.sq)
        sq_r[k] <= {{(SQ_W-COORD_W){1'b0}}, dmag[k]} * {{(SQ_W-COORD_W){1'b0}}, dmag[k]};
    end
    if (cmd.sum) begin
      // space occupies upper 4 lanes (k=7 is coordinate a), feat lower 4
      ssum_r <= DSUM_W'(sq_r[7])
              + ((sd_eff > 3'd1) ? DSUM_W'(sq_r[6]) : '0)
              + ((sd_eff > 3'd2) ? DSUM_W'(sq_r[5]) : '0)
              + ((sd_eff > 3'd3) ? DSUM_W'(sq_r[4]) : '0);
      fsum_r <= DSUM_W'(sq_r[3])
              + ((fd_eff > 3'd1) ? DSUM_W'(sq_r[2]) : '0)
              + ((fd_eff > 3'd2) ? DSUM_W'(sq_r[1]) : '0)
              + ((fd_eff > 3'd3) ? DSUM_W'(sq_r[0]) : '0);
    end
  end

  // Shared square root unit: spatial root during the pair pass, prefix root on output
  logic [BIDX_W-1:0] ob_r;
  logic [DSUM_W-1:0] run_r;
  logic [DSUM_W-1:0] sq_in;
  logic [ROOT_W-1:0] root;
  // fold the current bin into the running max as it enters the root unit
  assign sq_in = cmd.root_out ? ((brd_r > run_r) ? brd_r : run_r) : ssum_r;
  bpmp_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_start),
    .radicand (sq_in),
    .root     (root),
    .done     (sts.root_done)
  );

  // Restoring divider: bin = root / width, one quotient bit per cycle
  localparam int DC_W = $clog2(ROOT_W + 1);
  logic [ROOT_W-1:0] quo_r;
  logic [BW_W:0]     rem_r;
  logic [DC_W-1:0]   dcnt_r;
  logic [BW_W:0]     rsh;
  always_comb rsh = {rem_r[BW_W-1:0], quo_r[ROOT_W-1]};
  always_ff @(posedge clk) begin
    if (!rst_n) dcnt_r <= '0;
    else if (cmd.bin_step) begin
      if (dcnt_r == '0) begin
        quo_r  <= root;
        rem_r  <= '0;
        dcnt_r <= DC_W'(ROOT_W);
      end else begin
        if (rsh >= {1'b0, bw_eff}) begin
          rem_r <= rsh - {1'b0, bw_eff};
          quo_r <= {quo_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r <= rsh;
          quo_r <= {quo_r[ROOT_W-2:0], 1'b0};
        end
        dcnt_r <= dcnt_r - 1'b1;
      end
    end
  end
  assign sts.bin_done = (dcnt_r == DC_W'(1));

  logic [BA_W-1:0] bin_c;
  logic            clamp;
  assign clamp = ({1'b0, quo_r} > BIN_W'(MAX_BINS - 1));
  assign bin_c = clamp ? BA_W'(MAX_BINS - 1) : quo_r[BA_W-1:0];

  // Bin store: read-modify-write with registered read
  logic [DSUM_W-1:0] bmem [MAX_BINS];
  logic [DSUM_W-1:0] brd_r;
  logic [BA_W-1:0]   baddr;
  logic [BA_W-1:0]   hi_r;
  logic              ovf_r;
  logic [BA_W-1:0]   clr_r;
  assign baddr = cmd.rd_bin ? ob_r[BA_W-1:0] : bin_c;
  always_ff @(posedge clk) begin
    brd_r <= bmem[baddr];
    if (cmd.clr_bin) bmem[clr_r] <= '0;
    else if (cmd.upd && (fsum_r > brd_r)) bmem[bin_c] <= fsum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.run_clear) begin
      hi_r  <= '0;
      ovf_r <= 1'b0;
      clr_r <= '0;
    end else begin
      if (cmd.upd) begin
        if (bin_c > hi_r) hi_r <= bin_c;
        if (clamp) ovf_r <= 1'b1;
      end
      if (cmd.clr_bin) clr_r <= clr_r + 1'b1;
    end
  end
  assign sts.clr_last = (clr_r == BA_W'(MAX_BINS - 1));
  assign sts.bin_last = (ob_r[BA_W-1:0] == hi_r);

  // Output walk: running max and result register
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.run_clear) begin
      ob_r  <= '0;
      run_r <= '0;
    end else begin
      if (cmd.root_start && cmd.root_out && (brd_r > run_r)) run_r <= brd_r;
      if (cmd.out_load) ob_r <= ob_r + 1'b1;
    end
    if (cmd.out_load) begin
      out_bin_index       <= ob_r;
      out_prefix_max_dist <= root;
      out_bin_overflow    <= ovf_r;
      out_final_bin       <= sts.bin_last;
    end
  end

endmodule

@@ hdl/bpmp_ctrl.sv @@
// Controller: sequences loading, the pair pass, the output walk and the bin clear
`timescale 1ns / 1ps
module bpmp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_last_point,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bpmp_pkg::dp_cmd_t cmd,
  input  bpmp_pkg::dp_sts_t sts
);
  import bpmp_pkg::*;

  state_t st_r, st_nxt;
  logic   ov_r, ov_nxt;
  logic   rootwait_r, rootwait_nxt;

  // Start with a clearing pass so the bin store reads zero for the first set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_CLEAR;
      ov_r       <= 1'b0;
      rootwait_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      ov_r       <= ov_nxt;
      rootwait_r <= rootwait_nxt;
    end
  end

  always_comb begin
    st_nxt       = st_r;
    ov_nxt       = ov_r;
    rootwait_nxt = rootwait_r;
    cmd          = '0;
    in_ready     = 1'b0;
    if (out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store_pt = 1'b1;
          if (in_last_point) st_nxt = ST_PAIR_RD;
        end
      end
      ST_PAIR_RD:  begin cmd.rd_pair = 1'b1; st_nxt = ST_PAIR_SUB; end
      ST_PAIR_SUB: begin cmd.sub = 1'b1;     st_nxt = ST_PAIR_SQ;  end
      ST_PAIR_SQ:  begin cmd.sq = 1'b1;      st_nxt = ST_PAIR_SUM; end
      ST_PAIR_SUM: begin
        cmd.sum = 1'b1;
        rootwait_nxt = 1'b0;
        st_nxt = ST_PAIR_ROOT;
      end
      ST_PAIR_ROOT: begin
        if (!rootwait_r) begin
          cmd.root_start = 1'b1;
          rootwait_nxt = 1'b1;
        end else if (sts.root_done) begin
          cmd.bin_step = 1'b1;
          st_nxt = ST_PAIR_BIN;
        end
      end
      ST_PAIR_BIN: begin
        cmd.bin_step = 1'b1;
        if (sts.bin_done) st_nxt = ST_PAIR_LOOK;
      end
      // Read the bin store at the final bin index
      ST_PAIR_LOOK: st_nxt = ST_PAIR_UPD;
      ST_PAIR_UPD: begin
        cmd.upd = 1'b1;
        st_nxt = sts.pair_last ? ST_OUT_RD : ST_PAIR_RD;
      end
      ST_OUT_RD: begin
        cmd.rd_bin = 1'b1;
        rootwait_nxt = 1'b0;
        st_nxt = ST_OUT_ROOT;
      end
      ST_OUT_ROOT: begin
        cmd.root_out = 1'b1;
        if (!rootwait_r) begin
          cmd.root_start = 1'b1;
          rootwait_nxt = 1'b1;
        end else if (sts.root_done) begin
          st_nxt = ST_OUT_SEND;
        end
      end
      ST_OUT_SEND: begin
        if (!ov_r || out_ready) begin
          cmd.out_load = 1'b1;
          ov_nxt = 1'b1;
          st_nxt = sts.bin_last ? ST_CLEAR : ST_OUT_RD;
        end
      end
      ST_CLEAR: begin
        cmd.clr_bin = 1'b1;
        if (sts.clr_last) begin
          cmd.run_clear = 1'b1;
          st_nxt = ST_LOAD;
        end
      end
      default: st_nxt = ST_LOAD;
    endcase
  end

  assign out_valid = ov_r;

  a_no_load_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != ST_LOAD) |-> !in_ready) else $error("input taken during pass");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load) |-> (!ov_r || out_ready)) else $error("result overwritten");

endmodule

@@ hdl/binned_pairwise_max_prefix.sv @@
// Top level: binned pairwise feature-distance maximum with prefix output
`timescale 1ns / 1ps
// After reset a clearing pass zeroes the bin store before the first point
// is accepted. Points then load one per cycle into a point memory. After
// the point marked last, every ordered pair of N stored points is processed
// in sequence: read, subtract, square, sum, square root, bin division, bin
// lookup and update. Each bin up to the highest used is then emitted (read,
// shared square root, send); the receiver can stall the send. Afterward a
// clearing pass resets the bin store before the next point is accepted.
module binned_pairwise_max_prefix #(
  parameter int MAX_POINTS = bpmp_pkg::MAX_POINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [bpmp_pkg::BW_W-1:0]   cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [15:0]                 in_space_a,
  input  logic [15:0]                 in_space_b,
  input  logic [15:0]                 in_space_c,
  input  logic [15:0]                 in_space_d,
  input  logic [15:0]                 in_feat_a,
  input  logic [15:0]                 in_feat_b,
  input  logic [15:0]                 in_feat_c,
  input  logic [15:0]                 in_feat_d,
  input  logic                        in_last_point,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [5:0]                  out_bin_index,
  output logic [17:0]                 out_prefix_max_dist,
  output logic                        out_bin_overflow,
  output logic                        out_final_bin
);
  import bpmp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bpmp_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_point (in_last_point),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cmd           (cmd),
    .sts           (sts)
  );

  bpmp_datapath #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_space            ({in_space_a, in_space_b, in_space_c, in_space_d}),
    .in_feat             ({in_feat_a, in_feat_b, in_feat_c, in_feat_d}),
    .out_bin_index       (out_bin_index),
    .out_prefix_max_dist (out_prefix_max_dist),
    .out_bin_overflow    (out_bin_overflow),
    .out_final_bin       (out_final_bin)
  );

endmodule
